@@ design/lgs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Types and constants shared by the life generation stencil unit: beat
// payloads, register select codes and neighbourhood masks.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned CFG_W       = 11;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_SEL_BIT = 2;
  localparam int unsigned POS_W       = 10;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 11'd1024;

  // register select, taken from the word address
  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_sel_e;

  typedef enum logic {
    FUNC_CELL  = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  typedef struct packed {
    logic func;
    logic cell_alive;
  } cell_beat_t;

  typedef struct packed {
    logic             next_alive;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } result_beat_t;

  // which sides of the 3x3 window lie outside the grid
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } grid_border_t;

  // window bit layout: bits 0..2 left column, 3..5 centre, 6..8 right,
  // low bit of each column is the top row
  localparam logic [8:0] MASK_TOP    = 9'h049;
  localparam logic [8:0] MASK_BOTTOM = 9'h124;
  localparam logic [8:0] MASK_LEFT   = 9'h007;
  localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
  localparam int unsigned CENTER_BIT = 4;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage
`default_nettype wire

@@ design/lgs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_cell_if / lgs_result_if
// Valid/ready stream channels for cell beats and result beats.
// ----------------------------------------------------------------------------
interface lgs_cell_if;
  import lgs_pkg::*;

  logic       valid;
  logic       ready;
  cell_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lgs_result_if;
  import lgs_pkg::*;

  logic         valid;
  logic         ready;
  result_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/lgs_rule.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_rule
// B3/S23 next-state decision for the centre of a 3x3 window, with the sides
// that fall outside the grid forced dead.
// ----------------------------------------------------------------------------
module lgs_rule (
  input  logic [8:0]           window_i,
  input  lgs_pkg::grid_border_t border_i,
  output logic                 next_alive_o
);
  import lgs_pkg::*;

  logic [8:0] masked;
  logic [3:0] count;

  always_comb begin
    masked = window_i;
    if (border_i.top)    masked = masked & ~MASK_TOP;
    if (border_i.bottom) masked = masked & ~MASK_BOTTOM;
    if (border_i.left)   masked = masked & ~MASK_LEFT;
    if (border_i.right)  masked = masked & ~MASK_RIGHT;

    // eight neighbours, centre excluded
    count = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != CENTER_BIT) count = count + 4'(masked[i]);
    end

    if (masked[CENTER_BIT]) begin
      next_alive_o = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
    end else begin
      next_alive_o = (count == BIRTH_COUNT);
    end
  end

endmodule
`default_nettype wire

@@ design/life_generation_stencil_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_stencil_unit
// One generation of Conway's Life (B3/S23) over a raster-order cell stream.
// ----------------------------------------------------------------------------
// Takes one cell beat per clock unless stalled; once grid_cols + 1 beats are in,
// gives one result beat per cell beat: the next state of the cell that arrived
// grid_cols + 1 beats earlier, with its row, column and a frame_last flag on
// the final cell. After the last cell of a frame, send grid_cols + 1 drain
// beats (func = 1) to flush the tail; drain beats before the frame end and
// drain beats with nothing pending are swallowed without a result. The edge
// that accepts a beat also registers the read of the two row stores; the
// window shift and the rule then write the result register once stage 1
// advances, which waits while a held result is not taken. The row stores
// have one read and one write port each, and a forward path covers the read
// of a column written by the beat just ahead, so the unit sustains one beat
// per clock while no result is held back. The row stores need no clearing pass
// after reset: the top row of a frame has its upper neighbours forced dead,
// so no entry is read unmasked before this frame has written it. A register
// write restarts the frame; write registers only while the unit is idle.
// Dimensions of 0 act as 1, dimensions above MAX_ROWS / MAX_COLS saturate.
// ----------------------------------------------------------------------------
module life_generation_stencil_unit #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lgs_cell_if.sink                       cell_i,
  lgs_result_if.source                   result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lgs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lgs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lgs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import lgs_pkg::*;

  // column index / store address
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  // reported row index
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  // input row counter runs up to rows + 1 while draining
  localparam int unsigned ROWC_W = $clog2(MAX_ROWS + 2);
  // effective dimensions, 1 .. MAX
  localparam int unsigned COLS_W = $clog2(MAX_COLS + 1);
  localparam int unsigned ROWS_W = $clog2(MAX_ROWS + 1);

  // beat held between store read and window update
  typedef struct packed {
    logic             cell_bit;   // dead padding for drain beats
    logic [COL_W-1:0] col;        // store address of this beat
    logic             col_zero;
    logic             emit;       // this beat produces a result
    logic             last;       // result is the final cell of the frame
    grid_border_t     border;
    logic [ROW_W-1:0] rep_row;    // position of the reported cell
    logic [COL_W-1:0] rep_col;
    logic             fwd_hit;    // store read overtaken by the beat ahead
    logic             fwd_up;
    logic             fwd_mid;
  } stage_t;

  function automatic logic [12:0] clamp_dim(input logic [CFG_W-1:0] raw,
                                            input logic [12:0] maxv);
    logic [12:0] v;
    v = 13'(raw);
    if (raw == '0) v = 13'd1;
    else if (v > maxv) v = maxv;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  grid_rows_q;
  logic [CFG_W-1:0]  grid_cols_q;
  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic              cfg_wr;
  reg_sel_e          reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_sel_e'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_DIM_RESET;
      grid_cols_q <= GRID_DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_GRID_ROWS: grid_rows_q <= pwdata[CFG_W-1:0];
        REG_GRID_COLS: grid_cols_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_ROWS: prdata = APB_DATA_W'(grid_rows_q);
      REG_GRID_COLS: prdata = APB_DATA_W'(grid_cols_q);
      default:       prdata = '0;
    endcase
  end

  assign rows_eff = ROWS_W'(clamp_dim(grid_rows_q, 13'(MAX_ROWS)));
  assign cols_eff = COLS_W'(clamp_dim(grid_cols_q, 13'(MAX_COLS)));

  // --------------------------------------------------------------------------
  // input position and report position counters
  // --------------------------------------------------------------------------
  logic [ROWC_W-1:0] in_row_q;
  logic [COL_W-1:0]  in_col_q;
  logic [ROW_W-1:0]  rep_row_q;
  logic [COL_W-1:0]  rep_col_q;

  logic   cell_acc;
  logic   in_frame;
  logic   beat_used;
  logic   load_s1;
  logic   in_col_wrap;
  logic   emit_now;
  logic   rep_col_last;
  logic   rep_row_last;
  logic   frame_end;

  stage_t s1_d;
  stage_t s1_q;
  logic   s1_valid_q;
  logic   advance;
  logic   up_rd_q;
  logic   mid_rd_q;
  logic   s1_up_eff;
  logic   s1_mid_eff;

  assign cell_acc  = cell_i.valid && cell_i.ready;
  assign in_frame  = in_row_q < ROWC_W'(rows_eff);
  // drain beats inside the frame carry nothing
  assign beat_used = !(in_frame && (cell_i.payload.func == FUNC_DRAIN));
  assign load_s1   = cell_acc && beat_used;

  assign in_col_wrap  = (COLS_W'(in_col_q) + COLS_W'(1)) == cols_eff;
  // results start once grid_cols + 1 beats have gone in
  assign emit_now     = (in_row_q >= ROWC_W'(2)) ||
                        ((in_row_q == ROWC_W'(1)) && (in_col_q != '0));
  assign rep_col_last = (COLS_W'(rep_col_q) + COLS_W'(1)) == cols_eff;
  assign rep_row_last = (ROWS_W'(rep_row_q) + ROWS_W'(1)) == rows_eff;
  assign frame_end    = rep_row_last && rep_col_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      rep_row_q <= '0;
      rep_col_q <= '0;
    end else if (cfg_wr) begin
      // frame restart
      in_row_q  <= '0;
      in_col_q  <= '0;
      rep_row_q <= '0;
      rep_col_q <= '0;
    end else if (load_s1) begin
      if (emit_now && frame_end) begin
        // last cell reported, ready for the next frame
        in_row_q  <= '0;
        in_col_q  <= '0;
        rep_row_q <= '0;
        rep_col_q <= '0;
      end else begin
        if (in_col_wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + ROWC_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
        if (emit_now) begin
          if (rep_col_last) begin
            rep_col_q <= '0;
            rep_row_q <= rep_row_q + ROW_W'(1);
          end else begin
            rep_col_q <= rep_col_q + COL_W'(1);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: row store read
  // --------------------------------------------------------------------------
  logic result_valid_q;

  // stall only when a result must go out and the result register is held
  assign advance      = s1_valid_q && (!s1_q.emit || !result_valid_q || result_o.ready);
  assign cell_i.ready = !s1_valid_q || advance;

  // the beat ahead may still be writing the column being read
  assign s1_mid_eff = s1_q.fwd_hit ? s1_q.fwd_mid : mid_rd_q;
  assign s1_up_eff  = s1_q.fwd_hit ? s1_q.fwd_up  : up_rd_q;

  always_comb begin
    s1_d.cell_bit      = in_frame && cell_i.payload.cell_alive;
    s1_d.col           = in_col_q;
    s1_d.col_zero      = (in_col_q == '0);
    s1_d.emit          = emit_now;
    s1_d.last          = emit_now && frame_end;
    s1_d.border.top    = (rep_row_q == '0);
    s1_d.border.bottom = rep_row_last;
    s1_d.border.left   = (rep_col_q == '0);
    s1_d.border.right  = rep_col_last;
    s1_d.rep_row       = rep_row_q;
    s1_d.rep_col       = rep_col_q;
    s1_d.fwd_hit       = s1_valid_q && (s1_q.col == in_col_q);
    s1_d.fwd_up        = s1_mid_eff;
    s1_d.fwd_mid       = s1_q.cell_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cell_i.ready) begin
      s1_valid_q <= load_s1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) s1_q <= s1_d;
  end

  // row stores: upper holds the row two back, middle the row just before
  logic up_mem  [MAX_COLS];
  logic mid_mem [MAX_COLS];

  always_ff @(posedge clk_i) begin
    if (advance) up_mem[s1_q.col] <= s1_mid_eff;
    if (load_s1) up_rd_q <= up_mem[in_col_q];
  end

  always_ff @(posedge clk_i) begin
    if (advance) mid_mem[s1_q.col] <= s1_q.cell_bit;
    if (load_s1) mid_rd_q <= mid_mem[in_col_q];
  end

  // --------------------------------------------------------------------------
  // stage 2: window shift, rule, result register
  // --------------------------------------------------------------------------
  logic [8:0]   win_q;
  logic [2:0]   col_bits;
  logic [8:0]   win_shift;
  logic [8:0]   rule_win;
  logic         rule_alive;
  result_beat_t result_q;

  assign col_bits  = {s1_q.cell_bit, s1_mid_eff, s1_up_eff};
  assign win_shift = {col_bits, win_q[8:3]};
  // at column zero the reported cell is the last one of the row before, so
  // the window is taken before the new column comes in
  assign rule_win  = s1_q.col_zero ? {3'b000, win_q[8:3]} : win_shift;

  lgs_rule u_lgs_rule (
    .window_i     (rule_win),
    .border_i     (s1_q.border),
    .next_alive_o (rule_alive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_wr) begin
      win_q <= '0;
    end else if (advance) begin
      win_q <= (s1_q.emit && s1_q.last) ? '0 : win_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (advance && s1_q.emit) begin
      result_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_q.emit) begin
      result_q.next_alive <= rule_alive;
      result_q.out_row    <= POS_W'(s1_q.rep_row);
      result_q.out_col    <= POS_W'(s1_q.rep_col);
      result_q.frame_last <= s1_q.last;
    end
  end

  assign result_o.valid   = result_valid_q;
  assign result_o.payload = result_q;

endmodule
`default_nettype wire

@@ design/lgs_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the life generation stencil unit, bound to the top.
// ----------------------------------------------------------------------------
module lgs_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cell_ready_i,
  input logic                  result_valid_i,
  input logic                  result_ready_i,
  input lgs_pkg::result_beat_t result_i,
  input logic                  cfg_write_i
);
  import lgs_pkg::*;

  logic             result_acc;
  logic             have_prev_q;
  logic [POS_W-1:0] prev_row_q;
  logic [POS_W-1:0] prev_col_q;

  assign result_acc = result_valid_i && result_ready_i;

  // position of the previous result beat within the current frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (cfg_write_i) begin
      have_prev_q <= 1'b0;
    end else if (result_acc) begin
      have_prev_q <= !result_i.frame_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_acc) begin
      prev_row_q <= result_i.out_row;
      prev_col_q <= result_i.out_col;
    end
  end

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_ready_i |=> result_valid_i && $stable(result_i))
    else $error("result beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cell_ready_i |-> result_valid_i && !result_ready_i)
    else $error("cell input stalled without a held result");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_acc && !have_prev_q |-> result_i.out_row == '0 && result_i.out_col == '0)
    else $error("frame does not start at the origin");

  a_raster_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_acc && have_prev_q |->
      (result_i.out_row == prev_row_q && result_i.out_col == POS_W'(prev_col_q + 1'b1)) ||
      (result_i.out_row == POS_W'(prev_row_q + 1'b1) && result_i.out_col == '0))
    else $error("result beats out of raster order");

endmodule

bind life_generation_stencil_unit lgs_checker u_lgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cell_ready_i   (cell_i.ready),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .result_i       (result_o.payload),
  .cfg_write_i    (psel & penable & pwrite)
);
`default_nettype wire

@@ sim/life_generation_stencil_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_generation_stencil_unit_test
// Self-checking bench for the Life stencil unit. A queue-fed driver streams
// raster cell beats with random gaps, a monitor takes result beats with
// random back-pressure, and a behavioral model of the generation step
// predicts every result. Grid sizes change over APB between phases,
// including zero, oversized and full-width settings.
// ----------------------------------------------------------------------------
module life_generation_stencil_unit_test;
  import lgs_pkg::*;

  localparam int unsigned GRID_MAX_ROWS = 1024;
  localparam int unsigned GRID_MAX_COLS = 1024;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // accepted beats per idle stage
  localparam int unsigned STAGE_BEATS   = 200;
  localparam int unsigned RANDOM_BEATS  = 480;
  // cells sent into the saturated tall grid before it is cut
  localparam int unsigned SAT_BEATS     = 48;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // apb side, held quiet until a register write
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lgs_cell_if   cell_ch ();
  lgs_result_if result_ch ();

  life_generation_stencil_unit #(
    .MAX_ROWS (GRID_MAX_ROWS),
    .MAX_COLS (GRID_MAX_COLS)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_i   (cell_ch),
    .result_o (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // bookkeeping
  // --------------------------------------------------------------------------
  cell_beat_t   cell_queue[$];       // beats waiting for the driver
  result_beat_t pending_results[$];  // predicted results, oldest first

  int unsigned beats_pushed;
  int unsigned beats_in;
  int unsigned results_seen;
  int unsigned frames_done;
  int unsigned settings_written;
  int unsigned mismatches;
  int unsigned cycles;

  // --------------------------------------------------------------------------
  // generation model: own copy of the grid setting, row stores and window
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] grid_rows_cfg;
  logic [CFG_W-1:0] grid_cols_cfg;
  logic             upper_row [GRID_MAX_COLS];
  logic             middle_row[GRID_MAX_COLS];
  logic [8:0]       window_bits;
  int unsigned      in_row;
  int unsigned      in_col;
  int unsigned      emit_idx;

  // zero acts as one, anything past the maximum saturates
  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // b3/s23 on the window centre, sides off the grid read as dead
  function automatic logic life_next_state(input logic [8:0] w, input int unsigned er,
                                           input int unsigned ec, input int unsigned rows,
                                           input int unsigned cols);
    logic [8:0]  m;
    int unsigned n;
    m = w;
    if (er == 0)        m &= ~MASK_TOP;
    if (er + 1 == rows) m &= ~MASK_BOTTOM;
    if (ec == 0)        m &= ~MASK_LEFT;
    if (ec + 1 == cols) m &= ~MASK_RIGHT;
    n = 0;
    for (int i = 0; i < 9; i++) begin
      if (i != CENTER_BIT) n += 32'(m[i]);
    end
    if (m[CENTER_BIT]) return (n == 32'(SURVIVE_COUNT)) || (n == 32'(BIRTH_COUNT));
    return n == 32'(BIRTH_COUNT);
  endfunction

  task automatic restart_frame_model();
    window_bits = '0;
    in_row      = 0;
    in_col      = 0;
    emit_idx    = 0;
  endtask

  task automatic reset_model();
    grid_rows_cfg = GRID_DIM_RESET;
    grid_cols_cfg = GRID_DIM_RESET;
    for (int i = 0; i < GRID_MAX_COLS; i++) begin
      upper_row[i]  = 1'b0;
      middle_row[i] = 1'b0;
    end
    restart_frame_model();
  endtask

  // advance the model by one accepted beat, queue the result it releases
  task automatic predict_generation(input cell_beat_t b);
    int unsigned  rows, cols, col, er, ec;
    logic         in_frame, cur, emitting, nxt;
    logic [2:0]   column;
    result_beat_t r;
    rows     = eff_dim(32'(grid_rows_cfg), GRID_MAX_ROWS);
    cols     = eff_dim(32'(grid_cols_cfg), GRID_MAX_COLS);
    in_frame = in_row < rows;
    nxt      = 1'b0;
    // drain beats inside the frame are swallowed
    if (in_frame && b.func == FUNC_DRAIN) return;
    // past the last cell every beat pushes dead padding
    cur = in_frame ? b.cell_alive : 1'b0;
    col = in_col;
    if (col >= cols) begin
      restart_frame_model();
      col = 0;
    end
    emitting = (in_row * cols + in_col) >= cols + 1;
    er       = emit_idx / cols;
    ec       = emit_idx % cols;
    column   = {cur, middle_row[col], upper_row[col]};
    // at column 0 the centre is still the previous window's right column
    if (emitting && col == 0)
      nxt = life_next_state({3'b000, window_bits[8:3]}, er, ec, rows, cols);
    window_bits     = {column, window_bits[8:3]};
    upper_row[col]  = middle_row[col];
    middle_row[col] = cur;
    if (emitting && col != 0)
      nxt = life_next_state(window_bits, er, ec, rows, cols);
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
    end
    if (!emitting) return;
    r.next_alive = nxt;
    r.out_row    = er[POS_W-1:0];
    r.out_col    = ec[POS_W-1:0];
    r.frame_last = (emit_idx + 1 >= rows * cols);
    if (r.frame_last) restart_frame_model();
    else emit_idx++;
    pending_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    results_seen++;
    if (got.frame_last) frames_done++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result row %0d col %0d with nothing expected",
                                got.out_row, got.out_col));
      return;
    end
    want = pending_results.pop_front();
    if (got.next_alive !== want.next_alive)
      report_mismatch($sformatf("next_alive %0b, want %0b at row %0d col %0d",
                                got.next_alive, want.next_alive, want.out_row, want.out_col));
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
    if (got.out_col !== want.out_col)
      report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
    if (got.frame_last !== want.frame_last)
      report_mismatch($sformatf("frame_last %0b, want %0b at row %0d col %0d",
                                got.frame_last, want.frame_last, want.out_row, want.out_col));
  endtask

  // --------------------------------------------------------------------------
  // idling: sender sparse / receiver heavy, then swapped, then none
  // --------------------------------------------------------------------------
  function automatic int unsigned sender_idle_pct();
    if (beats_in < STAGE_BEATS) return 7;
    if (beats_in < 2 * STAGE_BEATS) return 59;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (beats_in < STAGE_BEATS) return 59;
    if (beats_in < 2 * STAGE_BEATS) return 7;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // driver: prediction happens on the edge where the beat is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cell_ch.valid && cell_ch.ready) begin
        predict_generation(cell_ch.payload);
        beats_in++;
      end
      if (!cell_ch.valid || cell_ch.ready) begin
        if (cell_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          cell_ch.payload <= cell_queue.pop_front();
          cell_ch.valid   <= 1'b1;
        end else begin
          cell_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) check_result(result_ch.payload);
      result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("life_generation_stencil_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(input func_e f, input logic alive);
    cell_beat_t b;
    b.func       = f;
    b.cell_alive = alive;
    cell_queue.push_back(b);
    beats_pushed++;
  endtask

  // every beat taken, every result back, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (beats_in != beats_pushed || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb setup then access phase; the write lands on the access edge
  task automatic write_reg(input reg_sel_e sel, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_GRID_ROWS) grid_rows_cfg = value[CFG_W-1:0];
    else grid_cols_cfg = value[CFG_W-1:0];
    // any write drops the frame in progress, stores are kept
    restart_frame_model();
    settings_written++;
  endtask

  task automatic set_grid(input int unsigned rows_val, input int unsigned cols_val);
    wait_idle();
    if ($urandom_range(1)) begin
      write_reg(REG_GRID_ROWS, rows_val);
      write_reg(REG_GRID_COLS, cols_val);
    end else begin
      write_reg(REG_GRID_COLS, cols_val);
      write_reg(REG_GRID_ROWS, rows_val);
    end
  endtask

  // one frame (or its first cut cells) with random density and stray drains;
  // a full frame gets its flush tail of mixed drain and padding cell beats
  task automatic run_frame(input int unsigned rows, input int unsigned cols,
                           input int unsigned cut, output int unsigned sent);
    int unsigned alive_pct;
    int unsigned noise_pct;
    alive_pct = $urandom_range(100);
    noise_pct = $urandom_range(1) ? 0 : 8;
    sent      = 0;
    for (int unsigned k = 0; k < cut; k++) begin
      if ($urandom_range(99) < noise_pct) push_beat(FUNC_DRAIN, 1'($urandom_range(1)));
      push_beat(FUNC_CELL, $urandom_range(99) < alive_pct);
      sent++;
    end
    if (cut == rows * cols) begin
      for (int unsigned k = 0; k <= cols; k++) begin
        push_beat(func_e'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
      // drain with nothing pending, lands at the start of the next frame
      if ($urandom_range(3) == 0) push_beat(FUNC_DRAIN, 1'($urandom_range(1)));
    end
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(9, 24);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rows, cols, rows_val, cols_val, frames, cut, sent, random_beats;

    cell_ch.valid   = 1'b0;
    cell_ch.payload = '0;
    result_ch.ready = 1'b0;
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset grid is 1024 x 1024: a few cells, then a write aborts the frame
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_CELL, 1'b0);
    push_beat(FUNC_CELL, 1'b1);

    // 3 x 3 vertical blinker turns horizontal
    set_grid(3, 3);
    push_beat(FUNC_DRAIN, 1'b1);   // nothing pending yet, swallowed
    push_beat(FUNC_CELL, 1'b0);
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_CELL, 1'b0);
    push_beat(FUNC_CELL, 1'b0);
    push_beat(FUNC_DRAIN, 1'b0);   // drain ahead of frame end, swallowed
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_CELL, 1'b0);
    push_beat(FUNC_CELL, 1'b0);
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_CELL, 1'b0);
    // tail: drains and cell beats past the end, alive bit must be dropped
    push_beat(FUNC_DRAIN, 1'b1);
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_DRAIN, 1'b0);
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_DRAIN, 1'b0);   // next frame start, swallowed
    // start of the next frame, cut short by the write below
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_CELL, 1'b1);

    // zero dimensions act as a single cell
    set_grid(0, 0);
    push_beat(FUNC_CELL, 1'b1);
    push_beat(FUNC_DRAIN, 1'b0);
    push_beat(FUNC_CELL, 1'b1);

    // oversized height saturates to a tall column, cut after its first rows
    set_grid(2047, 1);
    run_frame(GRID_MAX_ROWS, 1, SAT_BEATS, sent);
    // oversized width saturates to a full-width row, a few cells only
    set_grid(1, 2047);
    run_frame(1, GRID_MAX_COLS, 3, sent);

    // random small grids, a few frames per setting, sometimes cut short
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      rows_val = pick_dim();
      cols_val = pick_dim();
      rows     = eff_dim(rows_val, GRID_MAX_ROWS);
      cols     = eff_dim(cols_val, GRID_MAX_COLS);
      set_grid(rows_val, cols_val);
      frames = (rows * cols > 64) ? 1 : $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        cut = rows * cols;
        if (f + 1 == frames && $urandom_range(9) == 0) cut = $urandom_range(rows * cols - 1);
        run_frame(rows, cols, cut, sent);
        random_beats += sent;
      end
    end

    wait_idle();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d beats over %0d grid register writes, incl. zero and oversized",
             beats_in, settings_written);
    $display("checked %0d results in %0d complete frames, %0d mismatches",
             results_seen, frames_done, mismatches);
    if (mismatches == 0) begin
      $display("life_generation_stencil_unit verification clean");
    end else begin
      $display("life_generation_stencil_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/lgs_pkg.sv
design/lgs_if.sv
design/lgs_rule.sv
design/life_generation_stencil_unit.sv
design/lgs_checker.sv
sim/life_generation_stencil_unit_test.sv
